### design/vfm_pkg.sv
// Shared types, codes and constant tables of the voxel face mesher.
`timescale 1ns / 1ps

package vfm_pkg;

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_MESH    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [2:0] TYPE_AIR   = 3'd0;
    localparam logic [2:0] TYPE_GRASS = 3'd1;
    localparam logic [2:0] TYPE_DIRT  = 3'd2;
    localparam logic [2:0] TYPE_STONE = 3'd3;
    localparam logic [2:0] TYPE_WATER = 3'd4;
    localparam logic [2:0] TYPE_SAND  = 3'd5;

    localparam int FACE_LEFT   = 0;
    localparam int FACE_RIGHT  = 1;
    localparam int FACE_BOTTOM = 2;
    localparam int FACE_TOP    = 3;
    localparam int FACE_FRONT  = 4;
    localparam int FACE_BACK   = 5;
    localparam int NUM_FACES   = 6;

    localparam logic [2:0] ADDR_W = 3'd3;
    localparam logic ADDR_SEL_CHUNK_X = 1'b0;
    localparam logic ADDR_SEL_CHUNK_Z = 1'b1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_MESH    = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] voxel_x;
        logic [8:0] voxel_y;
        logic [4:0] voxel_z;
        logic [2:0] block_type;
    } cmd_t;

    typedef struct packed {
        logic q_full;
        logic clearing;
    } front_ctl_t;

    // {dx, dy, dz} of each corner, per face
    localparam logic [2:0] FACE_CORNER [NUM_FACES][4] = '{
        '{3'b001, 3'b010, 3'b000, 3'b011},
        '{3'b100, 3'b111, 3'b101, 3'b110},
        '{3'b001, 3'b100, 3'b101, 3'b000},
        '{3'b010, 3'b111, 3'b110, 3'b011},
        '{3'b000, 3'b110, 3'b100, 3'b010},
        '{3'b011, 3'b101, 3'b111, 3'b001}
    };

    function automatic logic [23:0] type_colour(input logic [2:0] btype);
        logic [23:0] rgb;
        case (btype)
            TYPE_GRASS: rgb = 24'h00FF00;
            TYPE_DIRT:  rgb = 24'h80590D;
            TYPE_STONE: rgb = 24'h808080;
            TYPE_WATER: rgb = 24'h0000FF;
            TYPE_SAND:  rgb = 24'hFFE600;
            default:    rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

endpackage

### design/vfm_in_if.sv
// Input item channel: voxel write, mesh and restart beats.
`timescale 1ns / 1ps

interface vfm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [4:0] voxel_x;
    logic [8:0] voxel_y;
    logic [4:0] voxel_z;
    logic [2:0] block_type;

    modport source (output valid, kind, voxel_x, voxel_y, voxel_z, block_type, input ready);
    modport sink   (input valid, kind, voxel_x, voxel_y, voxel_z, block_type, output ready);
endinterface

### design/vfm_out_if.sv
// Output vertex channel.
`timescale 1ns / 1ps

interface vfm_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] pos_x;
    logic        [9:0]  pos_y;
    logic signed [16:0] pos_z;
    logic        [7:0]  red;
    logic        [7:0]  green;
    logic        [7:0]  blue;
    logic        [2:0]  face_id;
    logic        [23:0] vertex_index;
    logic               last_vertex;

    modport source (output valid, pos_x, pos_y, pos_z, red, green, blue, face_id,
                    vertex_index, last_vertex, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, red, green, blue, face_id,
                    vertex_index, last_vertex, output ready);
endinterface

### design/vfm_front.sv
// Front end: accepts input beats, bounds-checks and classifies them into commands.
`timescale 1ns / 1ps

module vfm_front #(
    parameter int EDGE_SIZE     = 32,
    parameter int COLUMN_HEIGHT = 512
) (
    vfm_in_if.sink               vox_in,
    input  vfm_pkg::front_ctl_t  ctl,
    output logic                 push,
    output vfm_pkg::cmd_t        cmd
);

    logic in_grid;
    logic keep;

    assign vox_in.ready = !ctl.clearing && !ctl.q_full;

    assign in_grid = ({27'd0, vox_in.voxel_x} < 32'(EDGE_SIZE))
                  && ({23'd0, vox_in.voxel_y} < 32'(COLUMN_HEIGHT))
                  && ({27'd0, vox_in.voxel_z} < 32'(EDGE_SIZE));

    always_comb
    begin
        cmd.op         = vfm_pkg::OP_WRITE;
        cmd.voxel_x    = vox_in.voxel_x;
        cmd.voxel_y    = vox_in.voxel_y;
        cmd.voxel_z    = vox_in.voxel_z;
        cmd.block_type = vox_in.block_type;
        keep           = 1'b0;
        unique case (vox_in.kind)
            vfm_pkg::KIND_WRITE:
            begin
                cmd.op = vfm_pkg::OP_WRITE;
                keep   = in_grid;
            end
            vfm_pkg::KIND_MESH:
            begin
                cmd.op = vfm_pkg::OP_MESH;
                keep   = in_grid;
            end
            vfm_pkg::KIND_RESTART:
            begin
                cmd.op = vfm_pkg::OP_RESTART;
                keep   = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = vox_in.valid && vox_in.ready && keep;

endmodule

### design/vfm_cmd_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module vfm_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vfm_pkg::cmd_t cmd_in,
    input  logic          pop,
    output vfm_pkg::cmd_t head,
    output logic          q_valid,
    output logic          q_full
);

    vfm_pkg::cmd_t entry_reg [vfm_pkg::QDEPTH];
    logic [vfm_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [vfm_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [vfm_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [vfm_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [vfm_pkg::QCNT_W-1:0] count_reg;
    logic [vfm_pkg::QCNT_W-1:0] count_next;

    assign head    = entry_reg[rd_ptr_reg];
    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == vfm_pkg::QCNT_W'(vfm_pkg::QDEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + vfm_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + vfm_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + vfm_pkg::QCNT_W'(push) - vfm_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

### design/vfm_back.sv
// Back end: voxel store, neighbor reads, face culling and vertex output stage.
`timescale 1ns / 1ps

module vfm_back #(
    parameter int EDGE_SIZE     = 32,
    parameter int COLUMN_HEIGHT = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vfm_pkg::cmd_t      head,
    input  logic               q_valid,
    output logic               pop,
    output logic               clearing,
    input  logic signed [10:0] chunk_x,
    input  logic signed [10:0] chunk_z,
    vfm_out_if.source          vtx_out
);

    localparam int XW = $clog2(EDGE_SIZE);
    localparam int YW = $clog2(COLUMN_HEIGHT);
    localparam int ZW = XW;
    localparam int AW = XW + YW + ZW;

    localparam logic [2:0] STEP_CENTER = 3'd0;
    localparam logic [2:0] STEP_XM     = 3'd1;
    localparam logic [2:0] STEP_XP     = 3'd2;
    localparam logic [2:0] STEP_YM     = 3'd3;
    localparam logic [2:0] STEP_YP     = 3'd4;
    localparam logic [2:0] STEP_ZM     = 3'd5;
    localparam logic [2:0] STEP_ZP     = 3'd6;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_LAST  = 6'b001000,
        ST_EVAL  = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    logic [2:0] mem [2**AW];
    logic [2:0] rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [2:0]    mem_wdata;
    logic [AW-1:0] raddr;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [2:0]    step_reg, step_next;
    logic          cap_en_reg, cap_en_next;
    logic [2:0]    cap_step_reg, cap_step_next;
    logic [23:0]   vtx_cnt_reg, vtx_cnt_next;
    logic          ovalid_reg, ovalid_next;

    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [ZW-1:0] z_reg, z_next;
    logic [2:0]    type_reg, type_next;
    logic [5:0]    air_reg, air_next;
    logic [5:0]    mask_reg, mask_next;
    logic [1:0]    corner_reg, corner_next;
    logic [16:0]   base_x_reg, base_x_next;
    logic [16:0]   base_z_reg, base_z_next;

    logic [16:0] pos_x_reg, pos_x_next;
    logic [9:0]  pos_y_reg, pos_y_next;
    logic [16:0] pos_z_reg, pos_z_next;
    logic [23:0] rgb_reg, rgb_next;
    logic [2:0]  face_reg, face_next;
    logic [23:0] index_reg, index_next;
    logic        last_reg, last_next;

    logic [XW-1:0] ax;
    logic [YW-1:0] ay;
    logic [ZW-1:0] az;
    logic [5:0]    vis;
    logic [2:0]    cur_face;
    logic [5:0]    mask_clr;
    logic [2:0]    corner_off;
    logic          emit_go;
    logic [16:0]   cx_wide;
    logic [16:0]   cz_wide;

    assign clearing = (state_reg == ST_CLEAR);
    assign cx_wide  = {{6{chunk_x[10]}}, chunk_x};
    assign cz_wide  = {{6{chunk_z[10]}}, chunk_z};

    always_comb
    begin
        cur_face = 3'd0;
        for (int f = vfm_pkg::NUM_FACES - 1; f >= 0; f--)
        begin
            if (mask_reg[f])
            begin
                cur_face = 3'(f);
            end
        end
    end

    assign mask_clr   = mask_reg & ~(6'b000001 << cur_face);
    assign corner_off = vfm_pkg::FACE_CORNER[cur_face][corner_reg];
    assign emit_go    = (state_reg == ST_EMIT) && (!ovalid_reg || vtx_out.ready);

    assign vis[vfm_pkg::FACE_LEFT]   = (x_reg == '0) || air_reg[vfm_pkg::FACE_LEFT];
    assign vis[vfm_pkg::FACE_RIGHT]  = (x_reg == XW'(EDGE_SIZE - 1)) || air_reg[vfm_pkg::FACE_RIGHT];
    assign vis[vfm_pkg::FACE_BOTTOM] = (y_reg == '0) || air_reg[vfm_pkg::FACE_BOTTOM];
    assign vis[vfm_pkg::FACE_TOP]    = (y_reg == YW'(COLUMN_HEIGHT - 1))
                                    || air_reg[vfm_pkg::FACE_TOP];
    assign vis[vfm_pkg::FACE_FRONT]  = (z_reg == '0) || air_reg[vfm_pkg::FACE_FRONT];
    assign vis[vfm_pkg::FACE_BACK]   = (z_reg == ZW'(EDGE_SIZE - 1)) || air_reg[vfm_pkg::FACE_BACK];

    always_comb
    begin
        ax = x_reg;
        ay = y_reg;
        az = z_reg;
        case (step_reg)
            STEP_XM: ax = x_reg - XW'(1);
            STEP_XP: ax = x_reg + XW'(1);
            STEP_YM: ay = y_reg - YW'(1);
            STEP_YP: ay = y_reg + YW'(1);
            STEP_ZM: az = z_reg - ZW'(1);
            STEP_ZP: az = z_reg + ZW'(1);
            default: ;
        endcase
        raddr = {ax, ay, az};
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        step_next     = step_reg;
        vtx_cnt_next  = vtx_cnt_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        type_next     = type_reg;
        air_next      = air_reg;
        mask_next     = mask_reg;
        corner_next   = corner_reg;
        base_x_next   = base_x_reg;
        base_z_next   = base_z_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        pos_z_next    = pos_z_reg;
        rgb_next      = rgb_reg;
        face_next     = face_reg;
        index_next    = index_reg;
        last_next     = last_reg;
        ovalid_next   = ovalid_reg && !vtx_out.ready;
        cap_en_next   = (state_reg == ST_READ);
        cap_step_next = step_reg;
        mem_we        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_wdata     = vfm_pkg::TYPE_AIR;
        pop           = 1'b0;

        if (cap_en_reg)
        begin
            if (cap_step_reg == STEP_CENTER)
            begin
                type_next = rdata_reg;
            end
            else
            begin
                air_next[cap_step_reg - 3'd1] = (rdata_reg == vfm_pkg::TYPE_AIR);
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    unique case (head.op)
                        vfm_pkg::OP_WRITE:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = {XW'(head.voxel_x), YW'(head.voxel_y), ZW'(head.voxel_z)};
                            mem_wdata = head.block_type;
                        end
                        vfm_pkg::OP_RESTART:
                        begin
                            vtx_cnt_next = 24'd0;
                        end
                        vfm_pkg::OP_MESH:
                        begin
                            x_next     = XW'(head.voxel_x);
                            y_next     = YW'(head.voxel_y);
                            z_next     = ZW'(head.voxel_z);
                            step_next  = STEP_CENTER;
                            state_next = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_ZP)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                mask_next   = vis;
                corner_next = 2'd0;
                base_x_next = cx_wide * 17'(EDGE_SIZE) + 17'(x_reg);
                base_z_next = cz_wide * 17'(EDGE_SIZE) + 17'(z_reg);
                if ((type_reg == vfm_pkg::TYPE_AIR) || (vis == 6'd0))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    ovalid_next = 1'b1;
                    pos_x_next  = base_x_reg + 17'(corner_off[2]);
                    pos_y_next  = 10'(y_reg) + 10'(corner_off[1]);
                    pos_z_next  = base_z_reg + 17'(corner_off[0]);
                    rgb_next    = vfm_pkg::type_colour(type_reg);
                    face_next   = cur_face;
                    index_next  = vtx_cnt_reg + 24'(corner_reg);
                    last_next   = 1'b0;
                    corner_next = corner_reg + 2'd1;
                    if (corner_reg == 2'd3)
                    begin
                        mask_next    = mask_clr;
                        vtx_cnt_next = vtx_cnt_reg + 24'd4;
                        if (mask_clr == 6'd0)
                        begin
                            last_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            step_reg     <= STEP_CENTER;
            cap_en_reg   <= 1'b0;
            vtx_cnt_reg  <= 24'd0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            step_reg     <= step_next;
            cap_en_reg   <= cap_en_next;
            vtx_cnt_reg  <= vtx_cnt_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_step_reg <= cap_step_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        type_reg     <= type_next;
        air_reg      <= air_next;
        mask_reg     <= mask_next;
        corner_reg   <= corner_next;
        base_x_reg   <= base_x_next;
        base_z_reg   <= base_z_next;
        pos_x_reg    <= pos_x_next;
        pos_y_reg    <= pos_y_next;
        pos_z_reg    <= pos_z_next;
        rgb_reg      <= rgb_next;
        face_reg     <= face_next;
        index_reg    <= index_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign vtx_out.valid        = ovalid_reg;
    assign vtx_out.pos_x        = pos_x_reg;
    assign vtx_out.pos_y        = pos_y_reg;
    assign vtx_out.pos_z        = pos_z_reg;
    assign vtx_out.red          = rgb_reg[23:16];
    assign vtx_out.green        = rgb_reg[15:8];
    assign vtx_out.blue         = rgb_reg[7:0];
    assign vtx_out.face_id      = face_reg;
    assign vtx_out.vertex_index = index_reg;
    assign vtx_out.last_vertex  = last_reg;

    a_emit_has_face: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> mask_reg != 6'd0)
        else $error("emit state with no face left");

    a_cnt_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_cnt_reg[1:0] == 2'b00)
        else $error("vertex counter not face aligned");

    a_last_on_corner3: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && last_reg |-> index_reg[1:0] == 2'b11)
        else $error("last vertex not on fourth corner");

    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> face_reg <= 3'd5)
        else $error("face id out of range");

endmodule

### design/voxel_face_mesher_core.sv
// Top level of the voxel face mesher: APB registers, front end, queue and back end.
//
// vox_in carries one beat per item (kind, voxel_x/y/z, block_type); vtx_out carries
// one beat per vertex, four per visible face, last_vertex set on the final vertex of
// a mesh item. chunk_offset_x/z are written over APB at byte addresses 0 and 4.
// Write and restart beats are handled by the back end while idle. A mesh beat makes
// seven reads of the single-read-port voxel store, then emits four vertices per
// visible face through one output register, one per cycle while vtx_out is ready.
// A two-entry command queue lets the front end keep accepting while the back end
// is busy or the output is stalled; a stalled vtx_out holds its beat and backs up
// the back end, then the queue, then vox_in.ready.
// After reset the store's 2^(XW+YW+ZW) entries (524288 at the default sizes) are
// cleared one entry per cycle; vox_in.ready stays low during that pass while
// APB writes are taken as usual. The vertex counter and offsets reset to zero.
`timescale 1ns / 1ps

module voxel_face_mesher_core #(
    parameter int EDGE_SIZE     = 32,
    parameter int COLUMN_HEIGHT = 512
) (
    input  logic                         clk,
    input  logic                         rst_n,
    vfm_in_if.sink                       vox_in,
    vfm_out_if.source                    vtx_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vfm_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic signed [10:0] chunk_x_reg;
    logic signed [10:0] chunk_z_reg;
    logic               cfg_write;

    vfm_pkg::front_ctl_t ctl;
    vfm_pkg::cmd_t       cmd;
    vfm_pkg::cmd_t       head;
    logic                push;
    logic                pop;
    logic                q_valid;
    logic                q_full;
    logic                clearing;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_x_reg <= 11'sd0;
            chunk_z_reg <= 11'sd0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == vfm_pkg::ADDR_SEL_CHUNK_X)
            begin
                chunk_x_reg <= pwdata[10:0];
            end
            else
            begin
                chunk_z_reg <= pwdata[10:0];
            end
        end
    end

    assign prdata = (paddr[2] == vfm_pkg::ADDR_SEL_CHUNK_X)
                  ? {{21{chunk_x_reg[10]}}, chunk_x_reg}
                  : {{21{chunk_z_reg[10]}}, chunk_z_reg};

    assign ctl.q_full   = q_full;
    assign ctl.clearing = clearing;

    vfm_front #(
        .EDGE_SIZE     (EDGE_SIZE),
        .COLUMN_HEIGHT (COLUMN_HEIGHT)
    ) u_front (
        .vox_in (vox_in),
        .ctl    (ctl),
        .push   (push),
        .cmd    (cmd)
    );

    vfm_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (cmd),
        .pop     (pop),
        .head    (head),
        .q_valid (q_valid),
        .q_full  (q_full)
    );

    vfm_back #(
        .EDGE_SIZE     (EDGE_SIZE),
        .COLUMN_HEIGHT (COLUMN_HEIGHT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_valid  (q_valid),
        .pop      (pop),
        .clearing (clearing),
        .chunk_x  (chunk_x_reg),
        .chunk_z  (chunk_z_reg),
        .vtx_out  (vtx_out)
    );

endmodule
